// ===== sv/spjq_pkg.sv =====
// Shared types and constants for the stable priority job queue.
`default_nettype none
package spjq_pkg;

  localparam int QUEUE_DEPTH_DEF   = 16;
  localparam int USER_COUNT_DEF    = 16;
  localparam int PRINTER_COUNT_DEF = 4;

  localparam logic MODE_SUBMIT = 1'b0;
  localparam logic MODE_TAKE   = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_REJ_FULL = 3'd1,
    ST_REJ_USER = 3'd2,
    ST_TAKEN    = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_REJ_FULL,
    OP_REJ_USER,
    OP_EMPTY
  } op_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_HOLD
  } ctl_state_t;

  typedef struct packed {
    logic [15:0] num;
    logic [7:0]  usr;
    logic [15:0] pg;
    logic [7:0]  pri;
  } slot_t;

  typedef struct packed {
    op_t  op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/spjq_ctrl.sv =====
// Controller: handshake, item decode and output word hold state machine.
`default_nettype none
module spjq_ctrl
  import spjq_pkg::*;
#(
  parameter int USER_COUNT = USER_COUNT_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        in_mode,
  input  wire  [7:0] in_user_number,
  output logic       out_valid,
  input  wire        out_stall,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  ctl_state_t state_r, state_nxt;
  logic       accept;
  logic       user_bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign user_bad = (in_user_number == 8'd0) || (in_user_number > 8'(USER_COUNT));

  always_comb begin
    in_stall  = (state_r == CTL_HOLD) && out_stall;
    out_valid = (state_r == CTL_HOLD);
    accept    = in_valid && !in_stall;
    state_nxt = state_r;
    cmd.op       = OP_NONE;
    cmd.load_out = accept;
    unique case (state_r)
      CTL_IDLE: begin
        if (accept) state_nxt = CTL_HOLD;
      end
      CTL_HOLD: begin
        if (accept) state_nxt = CTL_HOLD;
        else if (!out_stall) state_nxt = CTL_IDLE;
      end
      default: state_nxt = CTL_IDLE;
    endcase
    if (accept) begin
      if (in_mode == MODE_TAKE) begin
        cmd.op = stat.empty ? OP_EMPTY : OP_REMOVE;
      end else if (user_bad) begin
        cmd.op = OP_REJ_USER;
      end else if (stat.full) begin
        cmd.op = OP_REJ_FULL;
      end else begin
        cmd.op = OP_INSERT;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_op_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_NONE) |-> (in_valid && !in_stall))
    else $error("operation issued without an accepted word");
  a_no_insert_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full |-> (cmd.op != OP_INSERT))
    else $error("insert issued into a full queue");
  a_hold_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("accepted word produced no result word");
`endif

endmodule
`default_nettype wire

// ===== sv/spjq_dp.sv =====
// Datapath: sorted slot array, counters and result word register.
`default_nettype none
module spjq_dp
  import spjq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int PRINTER_COUNT = PRINTER_COUNT_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  wire  [7:0]  in_user_number,
  input  wire  [15:0] in_page_count,
  input  wire  [7:0]  in_job_priority,
  output logic [2:0]  out_status,
  output logic [15:0] out_job_number,
  output logic [7:0]  out_owner,
  output logic [15:0] out_pages_out,
  output logic [7:0]  out_priority_out,
  output logic [2:0]  out_printer,
  output logic [4:0]  out_fill
);

  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = (PRINTER_COUNT > 1) ? $clog2(PRINTER_COUNT) : 1;

  slot_t          slot_r   [QUEUE_DEPTH];
  slot_t          slot_nxt [QUEUE_DEPTH];
  logic [OW-1:0]  occ_r, occ_nxt;
  logic [15:0]    num_r, num_nxt;
  logic [PW-1:0]  prn_r, prn_nxt;
  logic [PW:0]    prn_full;
  logic [QUEUE_DEPTH-1:0] cand;
  slot_t          new_slot;

  logic [2:0]  status_r, status_nxt;
  logic [15:0] jnum_r, jnum_nxt;
  logic [7:0]  owner_r, owner_nxt;
  logic [15:0] pages_r, pages_nxt;
  logic [7:0]  pri_r, pri_nxt;
  logic [2:0]  printer_r, printer_nxt;
  logic [4:0]  fill_r, fill_nxt;

  assign stat.empty = (occ_r == '0);
  assign stat.full  = (occ_r == OW'(QUEUE_DEPTH));
  assign prn_full   = {1'b0, prn_r} + 1'b1;

  always_comb begin
    new_slot.num = num_r;
    new_slot.usr = in_user_number;
    new_slot.pg  = in_page_count;
    new_slot.pri = in_job_priority;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cand[i] = ((OW'(i) < occ_r) && (slot_r[i].pri > in_job_priority)) ||
                (OW'(i) == occ_r);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) slot_nxt[i] = slot_r[i];
    occ_nxt = occ_r;
    num_nxt = num_r;
    prn_nxt = prn_r;
    status_nxt  = status_r;
    jnum_nxt    = jnum_r;
    owner_nxt   = owner_r;
    pages_nxt   = pages_r;
    pri_nxt     = pri_r;
    printer_nxt = printer_r;
    case (cmd.op)
      OP_INSERT: begin
        if (cand[0]) slot_nxt[0] = new_slot;
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (cand[i-1]) slot_nxt[i] = slot_r[i-1];
          else if (cand[i]) slot_nxt[i] = new_slot;
        end
        occ_nxt = occ_r + 1'b1;
        num_nxt = num_r + 16'd1;
      end
      OP_REMOVE: begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) slot_nxt[i] = slot_r[i+1];
        occ_nxt = occ_r - 1'b1;
        prn_nxt = (prn_r == PW'(PRINTER_COUNT - 1)) ? '0 : prn_r + 1'b1;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      jnum_nxt    = '0;
      owner_nxt   = '0;
      pages_nxt   = '0;
      pri_nxt     = '0;
      printer_nxt = '0;
      case (cmd.op)
        OP_INSERT: begin
          status_nxt = ST_ACCEPTED;
          jnum_nxt   = num_r;
        end
        OP_REMOVE: begin
          status_nxt  = ST_TAKEN;
          jnum_nxt    = slot_r[0].num;
          owner_nxt   = slot_r[0].usr;
          pages_nxt   = slot_r[0].pg;
          pri_nxt     = slot_r[0].pri;
          printer_nxt = 3'(prn_full);
        end
        OP_REJ_FULL: status_nxt = ST_REJ_FULL;
        OP_REJ_USER: status_nxt = ST_REJ_USER;
        default:     status_nxt = ST_EMPTY;
      endcase
    end
    fill_nxt = cmd.load_out ? 5'(occ_nxt) : fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      num_r <= 16'd1;
      prn_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      num_r <= num_nxt;
      prn_r <= prn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) slot_r[i] <= slot_nxt[i];
    status_r  <= status_nxt;
    jnum_r    <= jnum_nxt;
    owner_r   <= owner_nxt;
    pages_r   <= pages_nxt;
    pri_r     <= pri_nxt;
    printer_r <= printer_nxt;
    fill_r    <= fill_nxt;
  end

  assign out_status       = status_r;
  assign out_job_number   = jnum_r;
  assign out_owner        = owner_r;
  assign out_pages_out    = pages_r;
  assign out_priority_out = pri_r;
  assign out_printer      = printer_r;
  assign out_fill         = fill_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_INSERT) |=> (occ_r == $past(occ_r) + 1'b1))
    else $error("insert did not grow occupancy");
  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_REMOVE) |=> (occ_r == $past(occ_r) - 1'b1))
    else $error("remove did not shrink occupancy");
  a_reject_keeps_number: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_REJ_FULL || cmd.op == OP_REJ_USER) |=> $stable(num_r))
    else $error("rejected job consumed a job number");
`endif

endmodule
`default_nettype wire

// ===== sv/stable_priority_job_queue_core.sv =====
// Top level of the stable priority job queue.
//
//   channel  ports                                       direction
//   in       in_valid/in_stall, mode, user, pages, prio  item into the queue
//   out      out_valid/out_stall, status..fill           one result word per item
//
// One item per cycle while out_stall is low: the sorted slot row inserts or removes
// with every slot comparing and shifting in parallel. The result word sits in an
// output register; a new item is taken while it waits unless out_stall is high.
// Reset clears occupancy, sets the job number to 1 and points the printer at 1;
// slot contents are not cleared and need no clearing pass.
`default_nettype none
module stable_priority_job_queue_core
  import spjq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int USER_COUNT    = USER_COUNT_DEF,
  parameter int PRINTER_COUNT = PRINTER_COUNT_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_mode,
  input  wire  [7:0]  in_user_number,
  input  wire  [15:0] in_page_count,
  input  wire  [7:0]  in_job_priority,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_job_number,
  output logic [7:0]  out_owner,
  output logic [15:0] out_pages_out,
  output logic [7:0]  out_priority_out,
  output logic [2:0]  out_printer,
  output logic [4:0]  out_fill
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spjq_ctrl #(
    .USER_COUNT (USER_COUNT)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_user_number (in_user_number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .stat           (stat),
    .cmd            (cmd)
  );

  spjq_dp #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRINTER_COUNT (PRINTER_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_user_number   (in_user_number),
    .in_page_count    (in_page_count),
    .in_job_priority  (in_job_priority),
    .out_status       (out_status),
    .out_job_number   (out_job_number),
    .out_owner        (out_owner),
    .out_pages_out    (out_pages_out),
    .out_priority_out (out_priority_out),
    .out_printer      (out_printer),
    .out_fill         (out_fill)
  );

endmodule
`default_nettype wire
